// ===== hw/rtl/bch_generator_polynomial_macros.svh =====
// ----------------------------------------------------------------------------
// BCH generator polynomial assertion macros
// Shared concurrent assertion forms for the generator block.
// ----------------------------------------------------------------------------
`ifndef BCH_GENERATOR_POLYNOMIAL_MACROS_SVH
`define BCH_GENERATOR_POLYNOMIAL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BGP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define BGP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BGP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BGP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bgp_pkg.sv =====
// ----------------------------------------------------------------------------
// BCH generator polynomial package
// Constants, sequencer codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package bgp_pkg;
    localparam int BGP_MAX_DEGREE  = 10;
    localparam int BGP_TABLE_DEPTH = 1024;
    localparam int BGP_WORD_BITS   = 64;
    localparam int CFG_M_W   = 4;
    localparam int CFG_LEN_W = 10;
    localparam int CFG_T_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;
    localparam int WIDX_W    = 4;
    localparam int RED_W     = 10;
    localparam logic [CFG_M_W-1:0]   RST_DEGREE = 4'd4;
    localparam logic [CFG_LEN_W-1:0] RST_LENGTH = 10'd15;
    localparam logic [CFG_T_W-1:0]   RST_ERRORS = 9'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_ERRORS = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_PWR, ST_RRD, ST_RCHK, ST_WALK, ST_CMT,
        ST_I0, ST_I1, ST_I2, ST_I3, ST_STG0, ST_STG1, ST_PLOG, ST_PEXP,
        ST_PMUL, ST_OSET, ST_OA, ST_OB, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LAUNCH, OP_CLR, OP_PWR, OP_RRD, OP_RCHK, OP_WALK, OP_CMT,
        OP_I0, OP_I1, OP_I2, OP_I3, OP_STG0, OP_STG1, OP_PLOG, OP_PEXP,
        OP_PMUL, OP_OSET, OP_OA, OP_OB, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic seen;
        logic cnt_n;
        logic cnt_nm1;
        logic walk_done;
        logic rc_zero;
        logic stg_done;
        logic j_zero;
        logic bit_last;
        logic invalid;
        logic word_last;
    } t_stat;
endpackage
`default_nettype wire

// ===== hw/rtl/bch_generator_polynomial.sv =====
// ----------------------------------------------------------------------------
// BCH generator polynomial builder
// Builds GF(2^m) tables, selects cyclotomic cosets and multiplies the factors.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in         start, busy, i_start_request
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// result    out        o_strobe, o_word_index .. o_last_word
//
// A run clears the tables, builds the power and log tables, scans the cosets,
// forms the factor products over the roots and then emits the result words.
// The product loop does its log and exp lookups one after the other.
// Reset is synchronous and clears the sequencer; table contents are rebuilt
// on every run. Results are strobed for one cycle each and cannot be stalled.
`default_nettype none
`include "bch_generator_polynomial_macros.svh"
module bch_generator_polynomial
    import bgp_pkg::*;
#(
    parameter int MAX_DEGREE  = BGP_MAX_DEGREE,
    parameter int TABLE_DEPTH = BGP_TABLE_DEPTH,
    parameter int WORD_BITS   = BGP_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_start_request,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                      o_strobe,
    output logic [WIDX_W-1:0]         o_word_index,
    output logic [WORD_BITS-1:0]      o_poly_bits,
    output logic [RED_W-1:0]          o_redundancy,
    output logic [RED_W-1:0]          o_data_length,
    output logic                      o_params_invalid,
    output logic                      o_last_word
);
    logic [CFG_M_W-1:0]   r_degree;
    logic [CFG_LEN_W-1:0] r_length;
    logic [CFG_T_W-1:0]   r_errors;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_go;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= RST_DEGREE;
            r_length <= RST_LENGTH;
            r_errors <= RST_ERRORS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEGREE: r_degree <= i_cfg_data[CFG_M_W-1:0];
                CFG_LENGTH: r_length <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_ERRORS: r_errors <= i_cfg_data[CFG_T_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_go = start && !busy && i_start_request;

    bgp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    bgp_dp #(
        .MAX_DEGREE  (MAX_DEGREE),
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_degree     (r_degree),
        .i_cfg_length     (r_length),
        .i_cfg_errors     (r_errors),
        .o_stat           (w_stat),
        .o_word_index     (o_word_index),
        .o_poly_bits      (o_poly_bits),
        .o_redundancy     (o_redundancy),
        .o_data_length    (o_data_length),
        .o_params_invalid (o_params_invalid),
        .o_last_word      (o_last_word)
    );

    assign o_strobe = (w_cmd.op == OP_EMIT);

    `BGP_ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    `BGP_ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, w_go, busy)
    `BGP_ASSERT_IMPL(a_inv_last, i_clk, i_rst_n, o_strobe && o_params_invalid, o_last_word)
    `BGP_ASSERT_IMPL(a_len_sum, i_clk, i_rst_n, o_strobe && !o_params_invalid,
        ({1'b0, o_data_length} + {1'b0, o_redundancy}) == {1'b0, r_length})
endmodule
`default_nettype wire

// ===== hw/rtl/bgp_ctrl.sv =====
// ----------------------------------------------------------------------------
// BCH generator polynomial controller
// Sequences table build, coset scan, factor products and word output.
// ----------------------------------------------------------------------------
`default_nettype none
module bgp_ctrl
    import bgp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_go,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    o_cmd.op = OP_LAUNCH;
                    n_state  = ST_CLR;
                end
            end
            ST_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.cnt_n) n_state = ST_PWR;
            end
            ST_PWR: begin
                o_cmd.op = OP_PWR;
                if (i_stat.cnt_nm1) n_state = ST_RRD;
            end
            ST_RRD: begin
                o_cmd.op = OP_RRD;
                n_state  = ST_RCHK;
            end
            ST_RCHK: begin
                o_cmd.op = OP_RCHK;
                if (!i_stat.seen) n_state = ST_WALK;
                else if (i_stat.cnt_nm1) n_state = ST_I0;
                else n_state = ST_RRD;
            end
            ST_WALK: begin
                o_cmd.op = OP_WALK;
                if (i_stat.walk_done) n_state = ST_CMT;
            end
            ST_CMT: begin
                o_cmd.op = OP_CMT;
                n_state  = i_stat.cnt_nm1 ? ST_I0 : ST_RRD;
            end
            ST_I0: begin
                o_cmd.op = OP_I0;
                n_state  = i_stat.rc_zero ? ST_OSET : ST_I1;
            end
            ST_I1: begin
                o_cmd.op = OP_I1;
                n_state  = ST_I2;
            end
            ST_I2: begin
                o_cmd.op = OP_I2;
                n_state  = ST_I3;
            end
            ST_I3: begin
                o_cmd.op = OP_I3;
                n_state  = ST_STG0;
            end
            ST_STG0: begin
                o_cmd.op = OP_STG0;
                n_state  = i_stat.stg_done ? ST_OSET : ST_STG1;
            end
            ST_STG1: begin
                o_cmd.op = OP_STG1;
                n_state  = ST_PLOG;
            end
            ST_PLOG: begin
                o_cmd.op = OP_PLOG;
                n_state  = ST_PEXP;
            end
            ST_PEXP: begin
                o_cmd.op = OP_PEXP;
                n_state  = ST_PMUL;
            end
            ST_PMUL: begin
                o_cmd.op = OP_PMUL;
                n_state  = i_stat.j_zero ? ST_STG0 : ST_PLOG;
            end
            ST_OSET: begin
                o_cmd.op = OP_OSET;
                n_state  = i_stat.invalid ? ST_EMIT : ST_OA;
            end
            ST_OA: begin
                o_cmd.op = OP_OA;
                n_state  = ST_OB;
            end
            ST_OB: begin
                o_cmd.op = OP_OB;
                n_state  = i_stat.bit_last ? ST_EMIT : ST_OA;
            end
            ST_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_state  = i_stat.word_last ? ST_IDLE : ST_OA;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/bgp_dp.sv =====
// ----------------------------------------------------------------------------
// BCH generator polynomial datapath
// Field tables, coset marks, root list and coefficient memories with counters.
// ----------------------------------------------------------------------------
`default_nettype none
module bgp_dp
    import bgp_pkg::*;
#(
    parameter int MAX_DEGREE  = BGP_MAX_DEGREE,
    parameter int TABLE_DEPTH = BGP_TABLE_DEPTH,
    parameter int WORD_BITS   = BGP_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic [CFG_M_W-1:0]   i_cfg_degree,
    input  wire logic [CFG_LEN_W-1:0] i_cfg_length,
    input  wire logic [CFG_T_W-1:0]   i_cfg_errors,
    output t_stat                     o_stat,
    output logic [WIDX_W-1:0]         o_word_index,
    output logic [WORD_BITS-1:0]      o_poly_bits,
    output logic [RED_W-1:0]          o_redundancy,
    output logic [RED_W-1:0]          o_data_length,
    output logic                      o_params_invalid,
    output logic                      o_last_word
);
    localparam int VW  = MAX_DEGREE;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int MW  = $clog2(MAX_DEGREE + 1);
    localparam int BW  = $clog2(WORD_BITS);
    localparam int DW  = WIDX_W + BW;
    localparam int LW  = CFG_T_W + 1;
    localparam int XW  = ((VW > LW) ? VW : LW) + 1;
    localparam int CW  = ((DW > AW) ? DW : AW) + ((CFG_LEN_W > AW) ? CFG_LEN_W : AW) + 1;

    logic [VW-1:0] m_pow  [TABLE_DEPTH];
    logic [VW-1:0] m_log  [TABLE_DEPTH];
    logic          m_seen [TABLE_DEPTH];
    logic [VW-1:0] m_root [TABLE_DEPTH];
    logic [VW-1:0] m_coef [TABLE_DEPTH];

    logic [VW-1:0] q_pow, q_log, q_root, q_coef;
    logic          q_seen;

    logic          pow_we, log_we, seen_we, root_we, coef_we, seen_wd;
    logic [AW-1:0] pow_wa, log_wa, seen_wa, root_wa, coef_wa;
    logic [VW-1:0] pow_wd, log_wd, root_wd, coef_wd;
    logic [AW-1:0] pow_ra, log_ra, seen_ra, root_ra, coef_ra;

    logic [MW-1:0]     r_m;
    logic [VW-1:0]     r_n, r_cnt, r_prev, r_x, r_z, r_cur, r_pv;
    logic [LW-1:0]     r_limit;
    logic [AW-1:0]     r_rc, r_wcnt, r_i, r_j;
    logic              r_keep, r_inv;
    logic [RED_W-1:0]  r_k;
    logic [WIDX_W-1:0] r_word, r_wl;
    logic [DW-1:0]     r_deg;
    logic [WORD_BITS-1:0] r_bits;

    logic [MW-1:0]   m_clamp;
    logic [VW:0]     n_full;
    logic [VW-1:0]   pwr_v, top_bit;
    logic [VW:0]     x2, e_sum;
    logic [VW-1:0]   x_next, e_mod, prod;
    logic            coef_bit, inv_now;
    logic [AW-1:0]   wl_raw;
    logic [CW-1:0]   len_ext, rc_ext, deg_ext;

    always_comb begin
        if (i_cfg_degree < CFG_M_W'(2)) m_clamp = MW'(2);
        else if (i_cfg_degree > CFG_M_W'(MAX_DEGREE)) m_clamp = MW'(MAX_DEGREE);
        else m_clamp = MW'(i_cfg_degree);
        n_full  = ((VW+1)'(1) << m_clamp) - (VW+1)'(1);
        top_bit = VW'(1) << (r_m - MW'(1));
        if (r_cnt < VW'(r_m)) pwr_v = VW'(1) << r_cnt;
        else if (r_cnt == VW'(r_m)) pwr_v = VW'(3);
        else if ((r_prev & top_bit) != '0) pwr_v = VW'(3) ^ ((r_prev & ~top_bit) << 1);
        else pwr_v = r_prev << 1;
        x2 = {r_x, 1'b0};
        if (x2 >= {1'b0, r_n}) x_next = VW'(x2 - {1'b0, r_n});
        else x_next = x2[VW-1:0];
        e_sum = {1'b0, q_log} + {1'b0, r_z};
        if (e_sum >= {1'b0, r_n}) e_mod = VW'(e_sum - {1'b0, r_n});
        else e_mod = e_sum[VW-1:0];
        prod     = (r_cur == '0) ? '0 : q_pow;
        len_ext  = CW'(i_cfg_length);
        rc_ext   = CW'(r_rc);
        deg_ext  = CW'(r_deg);
        inv_now  = (len_ext < rc_ext);
        coef_bit = (deg_ext <= rc_ext) && (q_coef != '0);
        wl_raw   = r_rc >> BW;
    end

    always_comb begin
        pow_we = 1'b0; log_we = 1'b0; seen_we = 1'b0; root_we = 1'b0; coef_we = 1'b0;
        seen_wd = 1'b0;
        pow_wa = '0; log_wa = '0; seen_wa = '0; root_wa = '0; coef_wa = '0;
        pow_wd = '0; log_wd = '0; root_wd = '0; coef_wd = '0;
        pow_ra = '0; log_ra = '0; seen_ra = '0; root_ra = '0; coef_ra = '0;
        case (i_cmd.op)
            OP_CLR: begin
                log_we = 1'b1; log_wa = AW'(r_cnt);
                seen_we = 1'b1; seen_wa = AW'(r_cnt);
            end
            OP_PWR: begin
                pow_we = 1'b1; pow_wa = AW'(r_cnt); pow_wd = pwr_v;
                log_we = 1'b1; log_wa = AW'(pwr_v); log_wd = r_cnt;
            end
            OP_RRD: seen_ra = AW'(r_cnt);
            OP_WALK: begin
                seen_we = 1'b1; seen_wa = AW'(r_x); seen_wd = 1'b1;
                root_we = 1'b1; root_wa = r_rc + r_wcnt; root_wd = r_x;
            end
            OP_I0: begin
                root_ra = '0;
                coef_we = (r_rc == '0); coef_wa = '0; coef_wd = VW'(1);
            end
            OP_I1: pow_ra = AW'(q_root);
            OP_I2: begin
                coef_we = 1'b1; coef_wa = '0; coef_wd = q_pow;
            end
            OP_I3: begin
                coef_we = 1'b1; coef_wa = AW'(1); coef_wd = VW'(1);
            end
            OP_STG0: begin
                root_ra = r_i - AW'(1); coef_ra = r_i - AW'(1);
            end
            OP_STG1: begin
                coef_we = 1'b1; coef_wa = r_i; coef_wd = VW'(1);
            end
            OP_PLOG: begin
                log_ra = AW'(r_cur); coef_ra = r_j - AW'(1);
            end
            OP_PEXP: pow_ra = AW'(e_mod);
            OP_PMUL: begin
                coef_we = 1'b1; coef_wa = r_j;
                coef_wd = (r_j != '0) ? (r_pv ^ prod) : prod;
            end
            OP_OA: coef_ra = AW'(r_deg);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pow_we) m_pow[pow_wa] <= pow_wd;
        if (log_we) m_log[log_wa] <= log_wd;
        if (seen_we) m_seen[seen_wa] <= seen_wd;
        if (root_we) m_root[root_wa] <= root_wd;
        if (coef_we) m_coef[coef_wa] <= coef_wd;
        q_pow  <= m_pow[pow_ra];
        q_log  <= m_log[log_ra];
        q_seen <= m_seen[seen_ra];
        q_root <= m_root[root_ra];
        q_coef <= m_coef[coef_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= '0; r_n <= '0; r_cnt <= '0; r_rc <= '0; r_wcnt <= '0;
            r_i <= '0; r_j <= '0; r_keep <= 1'b0; r_inv <= 1'b0;
            r_word <= '0; r_wl <= '0; r_deg <= '0;
        end else begin
            case (i_cmd.op)
                OP_LAUNCH: begin
                    r_m     <= m_clamp;
                    r_n     <= n_full[VW-1:0];
                    r_limit <= {i_cfg_errors, 1'b0};
                    r_cnt   <= '0;
                    r_rc    <= '0;
                end
                OP_CLR: r_cnt <= (r_cnt == r_n) ? '0 : r_cnt + VW'(1);
                OP_PWR: begin
                    r_prev <= pwr_v;
                    r_cnt  <= (r_cnt == r_n - VW'(1)) ? VW'(1) : r_cnt + VW'(1);
                end
                OP_RCHK: begin
                    if (q_seen) begin
                        r_cnt <= r_cnt + VW'(1);
                    end else begin
                        r_x <= r_cnt; r_wcnt <= '0; r_keep <= 1'b0;
                    end
                end
                OP_WALK: begin
                    if (XW'(r_x) <= XW'(r_limit)) r_keep <= 1'b1;
                    r_wcnt <= r_wcnt + AW'(1);
                    r_x    <= x_next;
                end
                OP_CMT: begin
                    if (r_keep) r_rc <= r_rc + r_wcnt;
                    r_cnt <= r_cnt + VW'(1);
                end
                OP_I3: r_i <= AW'(2);
                OP_STG1: begin
                    r_z <= q_root; r_cur <= q_coef; r_j <= r_i - AW'(1);
                end
                OP_PEXP: r_pv <= q_coef;
                OP_PMUL: begin
                    r_cur <= r_pv;
                    if (r_j == '0) r_i <= r_i + AW'(1);
                    else r_j <= r_j - AW'(1);
                end
                OP_OSET: begin
                    r_inv  <= inv_now;
                    r_k    <= RED_W'(len_ext - rc_ext);
                    r_wl   <= (wl_raw > AW'({WIDX_W{1'b1}})) ? '1 : WIDX_W'(wl_raw);
                    r_deg  <= '0;
                    r_word <= '0;
                    r_bits <= '0;
                end
                OP_OB: begin
                    r_bits <= {coef_bit, r_bits[WORD_BITS-1:1]};
                    r_deg  <= r_deg + DW'(1);
                end
                OP_EMIT: begin
                    r_word <= r_word + WIDX_W'(1);
                    r_bits <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.seen      = q_seen;
        o_stat.cnt_n     = (r_cnt == r_n);
        o_stat.cnt_nm1   = (r_cnt == r_n - VW'(1));
        o_stat.walk_done = (x_next == r_cnt);
        o_stat.rc_zero   = (r_rc == '0);
        o_stat.stg_done  = (r_i > r_rc);
        o_stat.j_zero    = (r_j == '0);
        o_stat.bit_last  = (r_deg[BW-1:0] == '1);
        o_stat.invalid   = inv_now;
        o_stat.word_last = r_inv || (r_word == r_wl);
    end

    assign o_word_index     = r_word;
    assign o_poly_bits      = r_inv ? '0 : r_bits;
    assign o_redundancy     = RED_W'(r_rc);
    assign o_data_length    = r_inv ? '0 : r_k;
    assign o_params_invalid = r_inv;
    assign o_last_word      = r_inv || (r_word == r_wl);
endmodule
`default_nettype wire

// ===== test/bch_generator_polynomial_checker.sv =====
// ----------------------------------------------------------------------------
// BCH generator polynomial checker
// Watches the command, configuration and result channels of the generator.
// It keeps its own copy of the registers, predicts every result word of an
// accepted start beat and compares each strobed word with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module bch_generator_polynomial_checker
    import bgp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic                 i_start_request,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_strobe,
    input  wire logic [WIDX_W-1:0]    i_word_index,
    input  wire logic [63:0]          i_poly_bits,
    input  wire logic [RED_W-1:0]     i_redundancy,
    input  wire logic [RED_W-1:0]     i_data_length,
    input  wire logic                 i_params_invalid,
    input  wire logic                 i_last_word,
    output int                        o_failures,
    output int                        o_pending
);
    typedef struct packed {
        logic [WIDX_W-1:0] word_index;
        logic [63:0]       poly_bits;
        logic [RED_W-1:0]  redundancy;
        logic [RED_W-1:0]  data_length;
        logic              params_invalid;
        logic              last_word;
    } t_word;

    t_word word_q[$];
    logic [CFG_M_W-1:0]   degree_reg;
    logic [CFG_LEN_W-1:0] length_reg;
    logic [CFG_T_W-1:0]   errors_reg;

    int exp_tab [1024];
    int log_tab [1024];
    bit seen_tab [1024];
    int roots [1024];
    int coeffs [1025];
    int n_roots;
    int failures = 0;

    assign o_failures = failures;
    assign o_pending  = word_q.size();

    function automatic int mul_root(int v, int r, int n);
        if (v == 0) return 0;
        return exp_tab[((log_tab[v & 1023] + r) % n) & 1023];
    endfunction

    function automatic void predict_words();
        int m, n, top, prev, v, x, cnt, lim, k, words, deg;
        int coset [16];
        bit keep;
        t_word w;
        m = degree_reg;
        if (m < 2) m = 2;
        if (m > BGP_MAX_DEGREE) m = BGP_MAX_DEGREE;
        n = (1 << m) - 1;
        for (int i = 0; i < 1024; i++) log_tab[i] = 0;
        for (int i = 0; i < m; i++) begin
            exp_tab[i] = 1 << i;
            log_tab[(1 << i) & 1023] = i;
        end
        exp_tab[m] = 3;
        log_tab[3] = m;
        top = 1 << (m - 1);
        for (int i = m + 1; i < n; i++) begin
            prev = exp_tab[i - 1];
            v = (prev >= top) ? (3 ^ ((prev ^ top) << 1)) : (prev << 1);
            v = v & 1023;
            exp_tab[i & 1023] = v;
            log_tab[v] = i;
        end
        log_tab[0] = 0;

        lim = 2 * errors_reg;
        for (int i = 0; i < 1024; i++) seen_tab[i] = 0;
        n_roots = 0;
        for (int r = 1; r < n; r++) begin
            if (!seen_tab[r & 1023]) begin
                cnt = 0;
                keep = 0;
                x = r;
                do begin
                    seen_tab[x & 1023] = 1;
                    if (cnt < 16) begin
                        coset[cnt] = x;
                        cnt++;
                    end
                    if (x <= lim) keep = 1;
                    x = (x * 2) % n;
                end while (x != r && cnt < 16);
                if (keep)
                    for (int c = 0; c < cnt && n_roots < 1024; c++) begin
                        roots[n_roots] = coset[c];
                        n_roots++;
                    end
            end
        end

        for (int i = 0; i < 1025; i++) coeffs[i] = 0;
        if (n_roots == 0) begin
            coeffs[0] = 1;
        end else begin
            coeffs[0] = exp_tab[roots[0] & 1023];
            coeffs[1] = 1;
            for (int i = 2; i <= n_roots; i++) begin
                coeffs[i] = 1;
                for (int j = i - 1; j > 0; j--)
                    coeffs[j] = (coeffs[j - 1] ^ mul_root(coeffs[j], roots[i - 1], n)) & 16'hFFFF;
                coeffs[0] = mul_root(coeffs[0], roots[i - 1], n);
            end
        end

        k = int'(length_reg) - n_roots;
        if (k < 0) begin
            w = '0;
            w.redundancy = n_roots[RED_W-1:0];
            w.params_invalid = 1'b1;
            w.last_word = 1'b1;
            word_q.push_back(w);
            return;
        end
        words = n_roots / 64 + 1;
        if (words > 16) words = 16;
        for (int wi = 0; wi < words; wi++) begin
            w = '0;
            w.word_index = wi[WIDX_W-1:0];
            for (int j = 0; j < 64; j++) begin
                deg = wi * 64 + j;
                if (deg <= n_roots && coeffs[deg] != 0) w.poly_bits[j] = 1'b1;
            end
            w.redundancy = n_roots[RED_W-1:0];
            w.data_length = k[RED_W-1:0];
            w.last_word = (wi + 1 == words);
            word_q.push_back(w);
        end
    endfunction

    task automatic report(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        failures++;
    endtask

    always @(posedge i_clk) begin
        t_word got, want;
        if (!i_rst_n) begin
            degree_reg <= RST_DEGREE;
            length_reg <= RST_LENGTH;
            errors_reg <= RST_ERRORS;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEGREE: degree_reg <= i_cfg_data[CFG_M_W-1:0];
                    CFG_LENGTH: length_reg <= i_cfg_data[CFG_LEN_W-1:0];
                    CFG_ERRORS: errors_reg <= i_cfg_data[CFG_T_W-1:0];
                    default: ;
                endcase
            end
            if (i_strobe) begin
                got = {i_word_index, i_poly_bits, i_redundancy, i_data_length,
                       i_params_invalid, i_last_word};
                if (word_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = word_q.pop_front();
                    if (got.word_index !== want.word_index)
                        report($sformatf("word_index %0d, expected %0d",
                                         got.word_index, want.word_index));
                    if (got.poly_bits !== want.poly_bits)
                        report($sformatf("poly_bits %h, expected %h",
                                         got.poly_bits, want.poly_bits));
                    if (got.redundancy !== want.redundancy)
                        report($sformatf("redundancy %0d, expected %0d",
                                         got.redundancy, want.redundancy));
                    if (got.data_length !== want.data_length)
                        report($sformatf("data_length %0d, expected %0d",
                                         got.data_length, want.data_length));
                    if (got.params_invalid !== want.params_invalid)
                        report($sformatf("params_invalid %b, expected %b",
                                         got.params_invalid, want.params_invalid));
                    if (got.last_word !== want.last_word)
                        report($sformatf("last_word %b, expected %b",
                                         got.last_word, want.last_word));
                end
            end
            if (i_start && !i_busy && i_start_request)
                predict_words();
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_bch_generator_polynomial.sv =====
// ----------------------------------------------------------------------------
// BCH generator polynomial testbench
// Drives start beats and register writes into the generator under several
// field, length and error settings, with random sender gaps, and gives the
// verdict from the failure count of the checker, or fails on a watchdog.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_bch_generator_polynomial;
    import bgp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 600000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_start_request = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 o_strobe;
    logic [WIDX_W-1:0]    o_word_index;
    logic [63:0]          o_poly_bits;
    logic [RED_W-1:0]     o_redundancy;
    logic [RED_W-1:0]     o_data_length;
    logic                 o_params_invalid;
    logic                 o_last_word;
    int                   failures;
    int                   pending;
    int                   idle_pct = 0;
    int                   quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bch_generator_polynomial i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_start_request,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_strobe, .o_word_index, .o_poly_bits, .o_redundancy,
        .o_data_length, .o_params_invalid, .o_last_word
    );

    bch_generator_polynomial_checker u_check (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_start_request,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_strobe(o_strobe), .i_word_index(o_word_index), .i_poly_bits(o_poly_bits),
        .i_redundancy(o_redundancy), .i_data_length(o_data_length),
        .i_params_invalid(o_params_invalid), .i_last_word(o_last_word),
        .o_failures(failures), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_start(input logic req);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_start_request <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] m, input logic [9:0] len,
                              input logic [8:0] t, input bit unused_too);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DAT_W-1:0] dat [4];
        idx[0] = CFG_DEGREE;
        dat[0] = {6'($urandom_range(0, 63)), m};
        idx[1] = CFG_LENGTH;
        dat[1] = len;
        idx[2] = CFG_ERRORS;
        dat[2] = {1'($urandom_range(0, 1)), t};
        idx[3] = CFG_UNUSED;
        dat[3] = 10'($urandom);
        for (int k = 0; k < (unused_too ? 4 : 3); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= dat[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        int m, n, t;
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 7);
        n = (1 << ((m < 2) ? 2 : ((m > 10) ? 10 : m))) - 1;
        if (n > 127)
            t = $urandom_range(0, 12);
        else
            t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, n / 2);
        set_config(4'(m), ($urandom_range(0, 2) == 0) ? 10'($urandom) : 10'(n),
                   9'(t), 1'b0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_start(1'b1);
        send_start(1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd0, 10'd3, 9'd1, 1'b1);
        send_start(1'b1);
        drain();
        set_config(4'd1, 10'd1023, 9'd0, 1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd15, 10'd1023, 9'd3, 1'b0);
        send_start(1'b1);
        send_start(1'b0);
        drain();
        set_config(4'd5, 10'd1023, 9'd511, 1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd5, 10'd0, 9'd2, 1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd3, 10'd1, 9'd1, 1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd7, 10'd127, 9'd63, 1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd8, 10'd1023, 9'd127, 1'b0);
        send_start(1'b1);
        drain();
        set_config(4'd10, 10'd1023, 9'd1, 1'b0);
        send_start(1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 22 : ((phase == 1) ? 84 : 0);
            for (int item = 0; item < 34; item++) begin
                if (item % 6 == 0) begin
                    drain();
                    random_config();
                end
                send_start(($urandom_range(0, 4) != 0));
            end
        end
        drain();

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
